### hw/rtl/fsrw_pkg.sv
// Shared types, constants and word packing for the fractional-N register word generator.
package fsrw_pkg;

	localparam int unsigned PFD_HZ_DEF       = 25000000;
	localparam int unsigned FRAC_MODULUS_DEF = 2500;

	localparam int unsigned RF_W   = 33;
	localparam int unsigned INT_W  = 16;
	localparam int unsigned MOD_W  = 12;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned WIDX_W = 3;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 4;

	localparam logic [RF_W-1:0] PRESCALER_SWITCH_HZ = 33'd3000000000;
	localparam int unsigned BAND_CLK_MAX_HZ = 125000;
	localparam logic [INT_W-1:0] MIN_INT_89 = 16'd75;
	localparam logic [INT_W-1:0] MIN_INT_45 = 16'd23;

	// quotient bits resolved per divider stage
	localparam int unsigned DIV_BITS_PER_STAGE = 4;
	localparam int unsigned QUEUE_DEPTH = 4;

	// register numbers of the programming words
	localparam logic [WIDX_W-1:0] WREG_FREQ  = 3'd0;
	localparam logic [WIDX_W-1:0] WREG_PHASE = 3'd1;
	localparam logic [WIDX_W-1:0] WREG_CTRL  = 3'd2;
	localparam logic [WIDX_W-1:0] WREG_MISC  = 3'd3;
	localparam logic [WIDX_W-1:0] WREG_OUT   = 3'd4;
	localparam logic [WIDX_W-1:0] WREG_LOCK  = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NOISE_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MUX_OUT      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PUMP_CURRENT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POLARITY     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_CTRL  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCK_PIN     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MAIN_POWER   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SIDE_POWER   = 3'd7;

	typedef struct packed {
		logic [1:0] noise_mode;
		logic [2:0] mux_out_select;
		logic [3:0] pump_current;
		logic       detector_polarity;
		logic [3:0] output_controls;
		logic [1:0] lock_pin_mode;
		logic [1:0] main_power;
		logic [1:0] side_power;
	} cfg_t;

	typedef struct packed {
		logic [INT_W-1:0] int_val;
		logic [MOD_W-1:0] frac;
		logic             prescaler;
		logic             too_low;
		logic             lock_int_n;
	} item_t;

	function automatic logic [WORD_W-1:0] make_word(
		input logic [WIDX_W-1:0] idx,
		input item_t             it,
		input cfg_t              c,
		input logic [7:0]        band,
		input logic [MOD_W-1:0]  modu
	);
		logic [WORD_W-1:0] w;
		unique case (idx)
			WREG_FREQ: begin
				w = {1'b0, it.int_val, it.frac, 3'd0};
			end
			WREG_PHASE: begin
				w = (32'(it.prescaler) << 27) | (32'd1 << 15) | (32'(modu) << 3) | 32'd1;
			end
			WREG_CTRL: begin
				w = (32'(c.noise_mode) << 29) | (32'(c.mux_out_select) << 26)
				  | (32'd1 << 24) | (32'd1 << 14) | (32'(c.pump_current) << 9)
				  | (32'(it.lock_int_n) << 8) | (32'(c.detector_polarity) << 6) | 32'd2;
			end
			WREG_MISC: begin
				w = 32'd3;
			end
			WREG_OUT: begin
				w = (32'(c.output_controls[3]) << 23) | (32'(band) << 12)
				  | (32'(c.output_controls[2]) << 9) | (32'(c.output_controls[1]) << 8)
				  | (32'(c.side_power) << 6) | (32'(c.output_controls[0]) << 5)
				  | (32'(c.main_power) << 3) | 32'd4;
			end
			WREG_LOCK: begin
				w = (32'(c.lock_pin_mode) << 22) | (32'd3 << 19) | 32'd5;
			end
			default: begin
				w = '0;
			end
		endcase
		return w;
	endfunction

endpackage

### hw/rtl/fsrw_divpipe.sv
// Pipelined restoring divider by a constant, up to four quotient bits per stage.
module fsrw_divpipe #(
	parameter int unsigned NUM_W = fsrw_pkg::RF_W,
	parameter int unsigned Q_W   = 9,
	parameter int unsigned DIV   = fsrw_pkg::PFD_HZ_DEF,
	parameter int unsigned SB_W  = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_v,
	input  logic [NUM_W-1:0] in_num,
	input  logic [SB_W-1:0]  in_sb,
	output logic             out_v,
	output logic [Q_W-1:0]   out_q,
	output logic [$clog2(DIV+1)-1:0] out_rem,
	output logic [SB_W-1:0]  out_sb
);
	localparam int unsigned REM_W = $clog2(DIV + 1);
	localparam int unsigned BPS   = fsrw_pkg::DIV_BITS_PER_STAGE;
	localparam int unsigned NS    = (Q_W + BPS - 1) / BPS;
	localparam logic [REM_W:0] DIV_X = (REM_W + 1)'(DIV);

	// qx holds the numerator bits still to be consumed; quotient bits shift in at the bottom
	logic [REM_W-1:0] rem_in [NS];
	logic [Q_W-1:0]   qx_in  [NS];
	logic [SB_W-1:0]  sb_in  [NS];
	logic             v_in   [NS];
	logic [REM_W-1:0] rem_nx [NS];
	logic [Q_W-1:0]   qx_nx  [NS];
	logic [REM_W-1:0] rem_q  [NS];
	logic [Q_W-1:0]   qx_q   [NS];
	logic [SB_W-1:0]  sb_q   [NS];
	logic             v_q    [NS];

	for (genvar s = 0; s < NS; s++) begin : g_stg
		localparam int unsigned STEPS = ((Q_W - s * BPS) < BPS) ? (Q_W - s * BPS) : BPS;

		if (s == 0) begin : g_first
			assign rem_in[s] = REM_W'(in_num >> Q_W);
			assign qx_in[s]  = in_num[Q_W-1:0];
			assign sb_in[s]  = in_sb;
			assign v_in[s]   = in_v;
		end else begin : g_next
			assign rem_in[s] = rem_q[s-1];
			assign qx_in[s]  = qx_q[s-1];
			assign sb_in[s]  = sb_q[s-1];
			assign v_in[s]   = v_q[s-1];
		end

		always_comb begin : p_step
			logic [REM_W:0]   t;
			logic [REM_W-1:0] r;
			logic [Q_W-1:0]   q;
			r = rem_in[s];
			q = qx_in[s];
			t = '0;
			for (int k = 0; k < STEPS; k++) begin
				t = {r, q[Q_W-1]};
				if (t >= DIV_X) begin
					t = t - DIV_X;
					q = {q[Q_W-2:0], 1'b1};
				end else begin
					q = {q[Q_W-2:0], 1'b0};
				end
				r = t[REM_W-1:0];
			end
			rem_nx[s] = r;
			qx_nx[s]  = q;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[s] <= 1'b0;
			end else if (en) begin
				v_q[s] <= v_in[s];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[s] <= rem_nx[s];
				qx_q[s]  <= qx_nx[s];
				sb_q[s]  <= sb_in[s];
			end
		end
	end

	assign out_v   = v_q[NS-1];
	assign out_q   = qx_q[NS-1];
	assign out_rem = rem_q[NS-1];
	assign out_sb  = sb_q[NS-1];

endmodule

### hw/rtl/fsrw_front.sv
// Front end: takes a frequency, derives INT, FRAC, prescaler and lock mode in a pipeline.
module fsrw_front #(
	parameter int unsigned PFD_HZ       = fsrw_pkg::PFD_HZ_DEF,
	parameter int unsigned FRAC_MODULUS = fsrw_pkg::FRAC_MODULUS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [fsrw_pkg::RF_W-1:0] target_hz,
	input  logic                      q_full,
	output logic                      push,
	output fsrw_pkg::item_t           res
);
	localparam int unsigned REM_W  = $clog2(PFD_HZ + 1);
	localparam int unsigned QW_INT = fsrw_pkg::RF_W + 1 - REM_W;
	localparam int unsigned MOD_W  = fsrw_pkg::MOD_W;
	localparam int unsigned INT_W  = fsrw_pkg::INT_W;
	localparam int unsigned PROD_W = REM_W + MOD_W;
	localparam logic [MOD_W-1:0] MOD12 = MOD_W'(FRAC_MODULUS);

	logic                      en;
	logic                      v_s1;
	logic [fsrw_pkg::RF_W-1:0] rf_s1;
	logic                      pre_s1;
	logic                      a_v;
	logic [QW_INT-1:0]         a_q;
	logic [REM_W-1:0]          a_rem;
	logic                      a_pre;
	logic                      v_s2;
	logic [PROD_W-1:0]         prod_s2;
	logic [INT_W-1:0]          int_s2;
	logic                      pre_s2;
	logic                      b_v;
	logic [MOD_W-1:0]          b_q;
	logic [INT_W:0]            b_sb;
	logic                      v_s3;
	fsrw_pkg::item_t           res_s3;
	fsrw_pkg::item_t           res_nx;

	// whole pipe holds only when a finished item cannot enter the queue
	assign en       = !(v_s3 && q_full);
	assign in_stall = !en;
	assign push     = v_s3 && !q_full;
	assign res      = res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= a_v;
			v_s3 <= b_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rf_s1   <= target_hz;
			pre_s1  <= target_hz > fsrw_pkg::PRESCALER_SWITCH_HZ;
			prod_s2 <= PROD_W'(a_rem) * PROD_W'(MOD12);
			int_s2  <= INT_W'(a_q);
			pre_s2  <= a_pre;
			res_s3  <= res_nx;
		end
	end

	fsrw_divpipe #(
		.NUM_W (fsrw_pkg::RF_W),
		.Q_W   (QW_INT),
		.DIV   (PFD_HZ),
		.SB_W  (1)
	) u_div_int (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (v_s1),
		.in_num  (rf_s1),
		.in_sb   (pre_s1),
		.out_v   (a_v),
		.out_q   (a_q),
		.out_rem (a_rem),
		.out_sb  (a_pre)
	);

	// quotient of rem*modulus/pfd is below the modulus, so MOD_W bits suffice
	fsrw_divpipe #(
		.NUM_W (PROD_W),
		.Q_W   (MOD_W),
		.DIV   (PFD_HZ),
		.SB_W  (INT_W + 1)
	) u_div_frac (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (v_s2),
		.in_num  (prod_s2),
		.in_sb   ({pre_s2, int_s2}),
		.out_v   (b_v),
		.out_q   (b_q),
		.out_rem (),
		.out_sb  (b_sb)
	);

	always_comb begin
		res_nx.int_val    = b_sb[INT_W-1:0];
		res_nx.frac       = b_q;
		res_nx.prescaler  = b_sb[INT_W];
		res_nx.lock_int_n = (b_q == '0);
		if (b_sb[INT_W]) begin
			res_nx.too_low = b_sb[INT_W-1:0] < fsrw_pkg::MIN_INT_89;
		end else begin
			res_nx.too_low = b_sb[INT_W-1:0] < fsrw_pkg::MIN_INT_45;
		end
	end

endmodule

### hw/rtl/fsrw_queue.sv
// Small FIFO of classified items between the front and back ends.
module fsrw_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fsrw_pkg::item_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output fsrw_pkg::item_t head
);
	localparam int unsigned DEPTH = fsrw_pkg::QUEUE_DEPTH;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	fsrw_pkg::item_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### hw/rtl/fsrw_back.sv
// Back end: sequences the six programming words of each item into the output register.
module fsrw_back #(
	parameter int unsigned PFD_HZ       = fsrw_pkg::PFD_HZ_DEF,
	parameter int unsigned FRAC_MODULUS = fsrw_pkg::FRAC_MODULUS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fsrw_pkg::cfg_t               cfg,
	input  logic                         q_empty,
	input  fsrw_pkg::item_t              q_head,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [fsrw_pkg::WORD_W-1:0]  word,
	output logic [fsrw_pkg::WIDX_W-1:0]  word_index,
	output logic                         final_word,
	output logic                         int_too_low
);
	localparam int unsigned BAND_DIV =
		(PFD_HZ + fsrw_pkg::BAND_CLK_MAX_HZ - 1) / fsrw_pkg::BAND_CLK_MAX_HZ;
	localparam logic [7:0] BAND = 8'(BAND_DIV);
	localparam logic [fsrw_pkg::MOD_W-1:0] MOD12 = fsrw_pkg::MOD_W'(FRAC_MODULUS);

	logic                        ov_q;
	logic                        busy_q;
	logic [fsrw_pkg::WIDX_W-1:0] idx_q;
	fsrw_pkg::item_t             cur_q;
	logic [fsrw_pkg::WORD_W-1:0] word_q;
	logic [fsrw_pkg::WIDX_W-1:0] widx_q;
	logic                        fin_q;
	logic                        low_q;
	logic                        free;
	logic                        emit;
	fsrw_pkg::item_t             src;
	logic [fsrw_pkg::WIDX_W-1:0] sidx;

	// a fresh item starts straight from the queue head, so runs follow without a gap
	assign free = !ov_q || !out_stall;
	assign emit = free && (busy_q || !q_empty);
	assign pop  = free && !busy_q && !q_empty;
	assign src  = busy_q ? cur_q : q_head;
	assign sidx = busy_q ? idx_q : fsrw_pkg::WREG_LOCK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q   <= 1'b0;
			busy_q <= 1'b0;
			idx_q  <= fsrw_pkg::WREG_LOCK;
		end else begin
			if (free) begin
				ov_q <= emit;
			end
			if (emit) begin
				if (!busy_q) begin
					busy_q <= 1'b1;
					idx_q  <= fsrw_pkg::WREG_OUT;
				end else if (idx_q == fsrw_pkg::WREG_FREQ) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_head;
		end
		if (emit) begin
			word_q <= fsrw_pkg::make_word(sidx, src, cfg, BAND, MOD12);
			widx_q <= sidx;
			fin_q  <= (sidx == fsrw_pkg::WREG_FREQ);
			low_q  <= src.too_low;
		end
	end

	assign out_valid   = ov_q;
	assign word        = word_q;
	assign word_index  = widx_q;
	assign final_word  = fin_q;
	assign int_too_low = low_q;

endmodule

### hw/rtl/fracn_synth_register_word_generator.sv
// Top level: configuration registers, front end, item queue and word sequencer.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------------
//  in      | input     | in_valid / in_stall    | target_hz[32:0]
//  out     | output    | out_valid / out_stall  | word[31:0], word_index[2:0], final_word,
//          |           |                        | int_too_low
//  cfg     | input     | cfg_wr_en              | cfg_index[2:0], cfg_data[3:0]
//
// Each item yields six words, one per cycle from the back-end output register while
// out_stall is low. The front divider pipeline takes an item every cycle unless a full queue
// holds it; an item passes the input register, the INT divider stages, the product register,
// the FRAC divider stages, the result register, the queue and the back-end output register.
// Reset is asynchronous and clears all control state; there is no clearing pass. A stall on
// the output fills the four-entry queue, then holds the front end.
module fracn_synth_register_word_generator #(
	parameter int unsigned PFD_HZ       = fsrw_pkg::PFD_HZ_DEF,
	parameter int unsigned FRAC_MODULUS = fsrw_pkg::FRAC_MODULUS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [fsrw_pkg::RF_W-1:0]        target_hz,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [fsrw_pkg::WORD_W-1:0]      word,
	output logic [fsrw_pkg::WIDX_W-1:0]      word_index,
	output logic                             final_word,
	output logic                             int_too_low,
	input  logic                             cfg_wr_en,
	input  logic [fsrw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fsrw_pkg::CFG_DATA_W-1:0]  cfg_data
);
	fsrw_pkg::cfg_t  cfg_q;
	fsrw_pkg::item_t f_res;
	fsrw_pkg::item_t q_head;
	logic            f_push;
	logic            q_full;
	logic            q_empty;
	logic            q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.noise_mode        <= 2'd0;
			cfg_q.mux_out_select    <= 3'd0;
			cfg_q.pump_current      <= 4'd7;
			cfg_q.detector_polarity <= 1'b1;
			cfg_q.output_controls   <= 4'd15;
			cfg_q.lock_pin_mode     <= 2'd1;
			cfg_q.main_power        <= 2'd0;
			cfg_q.side_power        <= 2'd0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				fsrw_pkg::CFG_NOISE_MODE:   cfg_q.noise_mode        <= cfg_data[1:0];
				fsrw_pkg::CFG_MUX_OUT:      cfg_q.mux_out_select    <= cfg_data[2:0];
				fsrw_pkg::CFG_PUMP_CURRENT: cfg_q.pump_current      <= cfg_data[3:0];
				fsrw_pkg::CFG_POLARITY:     cfg_q.detector_polarity <= cfg_data[0];
				fsrw_pkg::CFG_OUTPUT_CTRL:  cfg_q.output_controls   <= cfg_data[3:0];
				fsrw_pkg::CFG_LOCK_PIN:     cfg_q.lock_pin_mode     <= cfg_data[1:0];
				fsrw_pkg::CFG_MAIN_POWER:   cfg_q.main_power        <= cfg_data[1:0];
				fsrw_pkg::CFG_SIDE_POWER:   cfg_q.side_power        <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	fsrw_front #(
		.PFD_HZ       (PFD_HZ),
		.FRAC_MODULUS (FRAC_MODULUS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.target_hz (target_hz),
		.q_full    (q_full),
		.push      (f_push),
		.res       (f_res)
	);

	fsrw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_data (f_res),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	fsrw_back #(
		.PFD_HZ       (PFD_HZ),
		.FRAC_MODULUS (FRAC_MODULUS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.word        (word),
		.word_index  (word_index),
		.final_word  (final_word),
		.int_too_low (int_too_low)
	);

endmodule

### hw/rtl/fsrw_checker.sv
// Port-level checks for the register word generator, bound to the top level.
module fsrw_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [fsrw_pkg::WORD_W-1:0]  word,
	input logic [fsrw_pkg::WIDX_W-1:0]  word_index,
	input logic                         final_word,
	input logic                         int_too_low
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(word) && $stable(word_index))
		else $error("output item changed while stalled");

	a_final_on_r0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (final_word == (word_index == fsrw_pkg::WREG_FREQ)))
		else $error("final_word does not match register 0");

	a_index_countdown: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && word_index != fsrw_pkg::WREG_FREQ) ##1 out_valid
		|-> word_index == $past(word_index) - 3'd1)
		else $error("word index did not step down within a run");

	a_flag_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && word_index != fsrw_pkg::WREG_FREQ) ##1 out_valid
		|-> int_too_low == $past(int_too_low))
		else $error("int_too_low changed within a run");

	a_misc_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && word_index == fsrw_pkg::WREG_MISC |-> word == 32'd3)
		else $error("register 3 word is not constant");

endmodule

bind fracn_synth_register_word_generator fsrw_checker u_fsrw_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.word        (word),
	.word_index  (word_index),
	.final_word  (final_word),
	.int_too_low (int_too_low)
);

### test/fsrw_word_checker.sv
// Checker for the register word generator: predicts the six words of each item and compares.
`timescale 1ns / 100ps

module fsrw_word_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [fsrw_pkg::RF_W-1:0]        target_hz,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic [fsrw_pkg::WORD_W-1:0]      word,
	input  logic [fsrw_pkg::WIDX_W-1:0]      word_index,
	input  logic                             final_word,
	input  logic                             int_too_low,
	input  logic                             cfg_wr_en,
	input  logic [fsrw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fsrw_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                               errors,
	output int                               pending
);
	localparam logic [63:0] PFD      = 64'(fsrw_pkg::PFD_HZ_DEF);
	localparam logic [63:0] BAND_CLK = 64'(fsrw_pkg::BAND_CLK_MAX_HZ);
	localparam logic [11:0] MODULUS  = 12'(fsrw_pkg::FRAC_MODULUS_DEF);

	typedef struct packed {
		logic [fsrw_pkg::WORD_W-1:0] bits;
		logic [fsrw_pkg::WIDX_W-1:0] reg_num;
		logic                        is_last;
		logic                        too_low;
	} prog_word_t;

	prog_word_t      expected_words[$];
	fsrw_pkg::cfg_t  shadow_cfg;

	task automatic flag_field(input string what, input logic [31:0] want, input logic [31:0] got);
		errors++;
		$display("%0t: %s expected %h, actual %h", $time, what, want, got);
	endtask

	// the six words of one frequency item, register 5 first
	task automatic queue_words(input logic [fsrw_pkg::RF_W-1:0] rf);
		logic [63:0]                 quo;
		logic [63:0]                 rem;
		logic [15:0]                 int_val;
		logic [11:0]                 frac;
		logic                        presc;
		logic                        low;
		logic                        int_lock;
		logic [7:0]                  band;
		logic [fsrw_pkg::WORD_W-1:0] w [6];
		prog_word_t                  e;
		quo = 64'(rf) / PFD;
		rem = 64'(rf) % PFD;
		int_val = quo[15:0];
		frac = 12'((rem * 64'(MODULUS)) / PFD);
		int_lock = (frac == 12'd0);
		presc = (rf > fsrw_pkg::PRESCALER_SWITCH_HZ);
		low = presc ? (int_val < fsrw_pkg::MIN_INT_89) : (int_val < fsrw_pkg::MIN_INT_45);
		band = 8'((PFD + BAND_CLK - 64'd1) / BAND_CLK);
		w[fsrw_pkg::WREG_FREQ]  = {1'b0, int_val, frac, 3'b000};
		w[fsrw_pkg::WREG_PHASE] = {4'd0, presc, 11'd0, 1'b1, 15'd0} | {17'd0, MODULUS, 3'd1};
		w[fsrw_pkg::WREG_CTRL]  = {1'b0, shadow_cfg.noise_mode, shadow_cfg.mux_out_select,
			1'b0, 1'b1, 9'd0, 1'b1, 1'b0, shadow_cfg.pump_current, int_lock, 1'b0,
			shadow_cfg.detector_polarity, 6'd2};
		w[fsrw_pkg::WREG_MISC]  = 32'd3;
		w[fsrw_pkg::WREG_OUT]   = {8'd0, shadow_cfg.output_controls[3], 3'd0, band, 2'd0,
			shadow_cfg.output_controls[2], shadow_cfg.output_controls[1],
			shadow_cfg.side_power, shadow_cfg.output_controls[0],
			shadow_cfg.main_power, 3'd4};
		w[fsrw_pkg::WREG_LOCK]  = {8'd0, shadow_cfg.lock_pin_mode, 3'd3, 19'd5};
		for (int k = int'(fsrw_pkg::WREG_LOCK); k >= int'(fsrw_pkg::WREG_FREQ); k--) begin
			e.bits = w[k];
			e.reg_num = 3'(k);
			e.is_last = (k == int'(fsrw_pkg::WREG_FREQ));
			e.too_low = low;
			expected_words.push_back(e);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		prog_word_t e;
		if (!arst_n) begin
			shadow_cfg.noise_mode        = 2'd0;
			shadow_cfg.mux_out_select    = 3'd0;
			shadow_cfg.pump_current      = 4'd7;
			shadow_cfg.detector_polarity = 1'b1;
			shadow_cfg.output_controls   = 4'd15;
			shadow_cfg.lock_pin_mode     = 2'd1;
			shadow_cfg.main_power        = 2'd0;
			shadow_cfg.side_power        = 2'd0;
			expected_words.delete();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					fsrw_pkg::CFG_NOISE_MODE:   shadow_cfg.noise_mode        = cfg_data[1:0];
					fsrw_pkg::CFG_MUX_OUT:      shadow_cfg.mux_out_select    = cfg_data[2:0];
					fsrw_pkg::CFG_PUMP_CURRENT: shadow_cfg.pump_current      = cfg_data[3:0];
					fsrw_pkg::CFG_POLARITY:     shadow_cfg.detector_polarity = cfg_data[0];
					fsrw_pkg::CFG_OUTPUT_CTRL:  shadow_cfg.output_controls   = cfg_data[3:0];
					fsrw_pkg::CFG_LOCK_PIN:     shadow_cfg.lock_pin_mode     = cfg_data[1:0];
					fsrw_pkg::CFG_MAIN_POWER:   shadow_cfg.main_power        = cfg_data[1:0];
					fsrw_pkg::CFG_SIDE_POWER:   shadow_cfg.side_power        = cfg_data[1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				queue_words(target_hz);
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					flag_field("word with nothing pending", 32'd0, word);
				end else begin
					e = expected_words.pop_front();
					if (word !== e.bits)
						flag_field("word", e.bits, word);
					if (word_index !== e.reg_num)
						flag_field("word_index", 32'(e.reg_num), 32'(word_index));
					if (final_word !== e.is_last)
						flag_field("final_word", 32'(e.is_last), 32'(final_word));
					if (int_too_low !== e.too_low)
						flag_field("int_too_low", 32'(e.too_low), 32'(int_too_low));
				end
			end
		end
		pending = expected_words.size();
	end

	initial begin
		errors = 0;
		pending = 0;
	end

endmodule

### test/tb_top.sv
// Testbench top for the register word generator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_stall;
	logic [fsrw_pkg::RF_W-1:0]       target_hz;
	logic                            out_valid;
	logic                            out_stall;
	logic [fsrw_pkg::WORD_W-1:0]     word;
	logic [fsrw_pkg::WIDX_W-1:0]     word_index;
	logic                            final_word;
	logic                            int_too_low;
	logic                            cfg_wr_en;
	logic [fsrw_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [fsrw_pkg::CFG_DATA_W-1:0] cfg_data;
	int                              word_errors;
	int                              words_pending;
	logic                            quiet_tail;
	logic                            hold_req;

	always #6 clk = ~clk;

	fracn_synth_register_word_generator i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.target_hz   (target_hz),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.word        (word),
		.word_index  (word_index),
		.final_word  (final_word),
		.int_too_low (int_too_low),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	fsrw_word_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.target_hz   (target_hz),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.word        (word),
		.word_index  (word_index),
		.final_word  (final_word),
		.int_too_low (int_too_low),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (word_errors),
		.pending     (words_pending)
	);

	function automatic logic [fsrw_pkg::RF_W-1:0] corner_freq(input int n);
		case (n)
			0:  return 33'd0;
			1:  return 33'd1;
			2:  return 33'd9999;         // nonzero remainder, FRAC still zero
			3:  return 33'd10000;        // smallest nonzero FRAC
			4:  return 33'd24999999;     // INT 0, largest FRAC
			5:  return 33'd25000000;
			6:  return 33'd574999999;    // INT 22, below the 4/5 minimum
			7:  return 33'd575000000;    // INT 23, at the 4/5 minimum
			8:  return 33'd2999999999;
			9:  return 33'd3000000000;   // exactly at the switch: still 4/5
			10: return 33'd3000000001;   // first 8/9 frequency
			11: return 33'd3000010000;
			12: return 33'd4294967295;
			13: return 33'd4294967296;
			14: return 33'd4400000000;
			15: return 33'h1_FFFF_FFFF;
			16: return 33'h1_5555_5555;
			17: return 33'h0_AAAA_AAAA;
			18: return 33'd1000000000;
			19: return 33'd1234567890;
			default: return 33'd4399999999;
		endcase
	endfunction

	function automatic logic [fsrw_pkg::RF_W-1:0] random_freq();
		logic [63:0] f;
		case ($urandom_range(0, 5))
			0: f = {31'd0, 1'($urandom_range(0, 1)), $urandom()};
			1: f = 64'($urandom_range(0, 175)) * 64'd25000000;
			2: f = 64'd2999990000 + 64'($urandom_range(0, 20000));
			3: f = 64'd574000000 + 64'($urandom_range(0, 2000000));
			4: f = 64'($urandom_range(0, 1000000));
			default: f = 64'($urandom_range(0, 175)) * 64'd25000000
				+ 64'($urandom_range(0, 24999999));
		endcase
		return f[fsrw_pkg::RF_W-1:0];
	endfunction

	// called and returns at a falling edge
	task automatic send_freq(input logic [fsrw_pkg::RF_W-1:0] f);
		if (!quiet_tail && $urandom_range(0, 7) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		target_hz = f;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [fsrw_pkg::CFG_IDX_W-1:0] idx,
		input logic [fsrw_pkg::CFG_DATA_W-1:0] d);
		cfg_index = idx;
		cfg_data = d;
		cfg_wr_en = 1'b1;
		@(negedge clk);
	endtask

	task automatic load_setting(input logic [3:0] noise, input logic [3:0] mux,
		input logic [3:0] pump, input logic [3:0] pol, input logic [3:0] outs,
		input logic [3:0] lock, input logic [3:0] mainp, input logic [3:0] sidep);
		write_reg(fsrw_pkg::CFG_NOISE_MODE, noise);
		write_reg(fsrw_pkg::CFG_MUX_OUT, mux);
		write_reg(fsrw_pkg::CFG_PUMP_CURRENT, pump);
		write_reg(fsrw_pkg::CFG_POLARITY, pol);
		write_reg(fsrw_pkg::CFG_OUTPUT_CTRL, outs);
		write_reg(fsrw_pkg::CFG_LOCK_PIN, lock);
		write_reg(fsrw_pkg::CFG_MAIN_POWER, mainp);
		write_reg(fsrw_pkg::CFG_SIDE_POWER, sidep);
		cfg_wr_en = 1'b0;
	endtask

	// drop valid, wait for every word, then let the pipeline go quiet
	task automatic settle();
		in_valid = 1'b0;
		while (words_pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		int   stall_left;
		logic hold_done;
		stall_left = 0;
		hold_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_stall = 1'b1;
				repeat (200) @(negedge clk);
			end
			if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
				out_stall = 1'b1;
				stall_left = $urandom_range(1, 19) - 1;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		target_hz = '0;
		cfg_wr_en = 1'b0;
		cfg_index = fsrw_pkg::CFG_NOISE_MODE;
		cfg_data = '0;
		quiet_tail = 1'b0;
		hold_req = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int n = 0; n < 21; n++)
			send_freq(corner_freq(n));
		settle();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: load_setting(4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0);
				1: load_setting(4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF, 4'hF);
				2: load_setting(4'd3, 4'd6, 4'd15, 4'd1, 4'd15, 4'd3, 4'd3, 4'd3);
				default: load_setting(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
					4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
					4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
					4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
			endcase
			if (phase == 7)
				quiet_tail = 1'b1;
			for (int n = 0; n < 44; n++) begin
				if (phase == 3 && n == 4)
					hold_req = 1'b1;
				send_freq(random_freq());
			end
			settle();
		end

		if (word_errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		#5000000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule

### sim.f
hw/rtl/fsrw_pkg.sv
hw/rtl/fsrw_divpipe.sv
hw/rtl/fsrw_front.sv
hw/rtl/fsrw_queue.sv
hw/rtl/fsrw_back.sv
hw/rtl/fracn_synth_register_word_generator.sv
hw/rtl/fsrw_checker.sv
test/fsrw_word_checker.sv
test/tb_top.sv
